// ===== hw/rtl/udm_pkg.sv =====
// ----------------------------------------------------------------------------
// udm_pkg
// Shared width constants and pipeline payload type for the 64-bit unsigned
// divider.
// ----------------------------------------------------------------------------
package udm_pkg;

   localparam int FIELD_WIDTH = 64;          // port width of every operand/result
   localparam int DATA_WIDTH  = 64;          // arithmetic width, 8..64
   localparam int LATENCY     = DATA_WIDTH + 1;

   typedef struct packed {
      logic                    divide_by_zero;
      logic [DATA_WIDTH-1:0]   rem;          // partial remainder
      logic [DATA_WIDTH-1:0]   work;         // dividend bits out, quotient bits in
      logic [DATA_WIDTH-1:0]   divisor;
   } payload_type;

endpackage
// ----------------------------------------------------------------------------

// ===== hw/rtl/udm_stage.sv =====
// ----------------------------------------------------------------------------
// udm_stage
// One restoring division step: retires one quotient bit and registers the
// updated partial remainder.
// ----------------------------------------------------------------------------
module udm_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 prev_valid,
   input  udm_pkg::payload_type prev,
   output logic                 stage_valid,
   output udm_pkg::payload_type stage
);

   logic [udm_pkg::DATA_WIDTH:0]   trial;
   logic [udm_pkg::DATA_WIDTH:0]   diff;
   logic                           fits;
   udm_pkg::payload_type           stage_in;
   udm_pkg::payload_type           stage_ff;
   logic                           valid_ff;

   always_comb begin
      trial          = {prev.rem, prev.work[udm_pkg::DATA_WIDTH-1]};
      diff           = trial - {1'b0, prev.divisor};
      fits           = ~diff[udm_pkg::DATA_WIDTH];
      stage_in       = prev;
      stage_in.rem   = fits ? diff[udm_pkg::DATA_WIDTH-1:0] : trial[udm_pkg::DATA_WIDTH-1:0];
      stage_in.work  = {prev.work[udm_pkg::DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule
// ----------------------------------------------------------------------------

// ===== hw/rtl/unsigned_divmod_64.sv =====
// ----------------------------------------------------------------------------
// unsigned_divmod_64
// Pipelined unsigned 64-bit divider returning quotient and remainder.
// ----------------------------------------------------------------------------
// A request (req_dividend, req_divisor) is taken on every clock edge with
// start high; busy is always low, so one request may be issued each cycle.
// The result appears on the rsp_ ports with rsp_valid high for one cycle,
// after one input register plus one restoring-division stage per quotient
// bit, in request order. The receiver cannot stall the pipeline. A zero
// divisor raises rsp_divide_by_zero with an all-ones quotient and the
// dividend as the remainder.
// ----------------------------------------------------------------------------
module unsigned_divmod_64 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [udm_pkg::FIELD_WIDTH-1:0]   req_dividend,
   input  logic [udm_pkg::FIELD_WIDTH-1:0]   req_divisor,
   output logic                              rsp_valid,
   output logic [udm_pkg::FIELD_WIDTH-1:0]   rsp_quotient,
   output logic [udm_pkg::FIELD_WIDTH-1:0]   rsp_remainder,
   output logic                              rsp_divide_by_zero
);

   logic                   accept;
   udm_pkg::payload_type   entry_in;
   udm_pkg::payload_type   entry_ff;
   logic                   entry_valid_ff;
   logic                   chain_valid [0:udm_pkg::DATA_WIDTH];
   udm_pkg::payload_type   chain       [0:udm_pkg::DATA_WIDTH];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      entry_in.rem            = '0;
      entry_in.work           = req_dividend[udm_pkg::DATA_WIDTH-1:0];
      entry_in.divisor        = req_divisor[udm_pkg::DATA_WIDTH-1:0];
      entry_in.divide_by_zero = (req_divisor[udm_pkg::DATA_WIDTH-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain[0]       = entry_ff;

   genvar i;
   generate
      for (i = 0; i < udm_pkg::DATA_WIDTH; i++) begin : g_step
         udm_stage u_stage (
            .clock       (clock),
            .reset       (reset),
            .prev_valid  (chain_valid[i]),
            .prev        (chain[i]),
            .stage_valid (chain_valid[i+1]),
            .stage       (chain[i+1])
         );
      end
   endgenerate

   assign rsp_valid          = chain_valid[udm_pkg::DATA_WIDTH];
   assign rsp_quotient       = udm_pkg::FIELD_WIDTH'(chain[udm_pkg::DATA_WIDTH].work);
   assign rsp_remainder      = udm_pkg::FIELD_WIDTH'(chain[udm_pkg::DATA_WIDTH].rem);
   assign rsp_divide_by_zero = chain[udm_pkg::DATA_WIDTH].divide_by_zero;

   // every result traces back to an earlier accepted request
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, udm_pkg::LATENCY))
      else $error("result without matching request");

   // zero divisor must yield an all-ones quotient
   a_dbz_quotient: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (chain[udm_pkg::DATA_WIDTH].work == {udm_pkg::DATA_WIDTH{1'b1}}))
      else $error("divide by zero quotient not all ones");

   // remainder is fully reduced
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_divide_by_zero) |->
         (chain[udm_pkg::DATA_WIDTH].rem < chain[udm_pkg::DATA_WIDTH].divisor))
      else $error("remainder not below divisor");

endmodule
// ----------------------------------------------------------------------------

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for unsigned_divmod_64. A table of edge-case
// requests runs first, then shaped random requests with random gaps and
// back-to-back bursts. Every response is checked in order, field by field,
// against pinned values or a behavioral divide/modulo model in the testbench.
// ----------------------------------------------------------------------------
module tb_top;

   typedef logic [udm_pkg::FIELD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     divide_by_zero;
   } divmod_result_type;

   typedef struct packed {
      word_type          dividend;
      word_type          divisor;
      logic              pinned;
      divmod_result_type result;
   } request_row_type;

   localparam word_type ONES            = '1;
   localparam word_type TOP             = word_type'(1) << (udm_pkg::FIELD_WIDTH - 1);
   localparam int       RANDOM_REQUESTS = 550;
   localparam int       DRAIN_LIMIT     = 20 * udm_pkg::LATENCY;
   localparam int       NUM_DIRECTED    = 22;

   // pinned rows carry the expected response; others go through the predictor
   localparam request_row_type DIRECTED [NUM_DIRECTED] = '{
      '{64'h0, 64'h0, 1'b1, '{ONES, 64'h0, 1'b1}},
      '{ONES, 64'h0, 1'b1, '{ONES, ONES, 1'b1}},
      '{64'h0123_4567_89AB_CDEF, 64'h0, 1'b1, '{ONES, 64'h0123_4567_89AB_CDEF, 1'b1}},
      '{64'h0, 64'h1, 1'b1, '{64'h0, 64'h0, 1'b0}},
      '{ONES, 64'h1, 1'b1, '{ONES, 64'h0, 1'b0}},
      '{ONES, ONES, 1'b1, '{64'h1, 64'h0, 1'b0}},
      '{64'h0, ONES, 1'b1, '{64'h0, 64'h0, 1'b0}},
      '{64'h1, ONES, 1'b1, '{64'h0, 64'h1, 1'b0}},
      '{ONES - 1, ONES, 1'b1, '{64'h0, ONES - 1, 1'b0}},
      '{ONES, TOP, 1'b1, '{64'h1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0}},
      '{TOP, TOP, 1'b1, '{64'h1, 64'h0, 1'b0}},
      '{64'hC000_0000_0000_0000, 64'h8000_0000_0000_0001, 1'b1,
        '{64'h1, 64'h3FFF_FFFF_FFFF_FFFF, 1'b0}},
      '{64'h7FFF_FFFF_FFFF_FFFF, TOP, 1'b1, '{64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0}},
      '{ONES, 64'h2, 1'b1, '{64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 1'b0}},
      '{64'd100, 64'd7, 1'b1, '{64'd14, 64'd2, 1'b0}},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, '{64'h2, 64'h0, 1'b0}},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, '0},
      '{64'h1234_5678_9ABC_DEF0, 64'h0000_0001_0000_0000, 1'b0, '0},
      '{64'hDEAD_BEEF_CAFE_BABE, 64'h0000_0000_0001_2345, 1'b0, '0},
      '{TOP, 64'h0000_0001_0000_0001, 1'b0, '0},
      '{64'hFEDC_BA98_7654_3210, 64'h8765_4321_0FED_CBA9, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   word_type          req_dividend = '0;
   word_type          req_divisor = '0;
   logic              rsp_valid;
   word_type          rsp_quotient;
   word_type          rsp_remainder;
   logic              rsp_divide_by_zero;

   logic              pin_valid = 1'b0;
   divmod_result_type pin_result = '0;
   divmod_result_type pending_results [$];
   int                mismatch_count = 0;

   unsigned_divmod_64 dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic divmod_result_type divmod_predict(word_type dvd, word_type dvs);
      word_type          mask;
      word_type          a;
      word_type          b;
      divmod_result_type r;
      mask = ONES >> (udm_pkg::FIELD_WIDTH - udm_pkg::DATA_WIDTH);
      a = dvd & mask;
      b = dvs & mask;
      if (b == '0) begin
         r.quotient       = mask;
         r.remainder      = a;
         r.divide_by_zero = 1'b1;
      end else begin
         r.quotient       = a / b;
         r.remainder      = a % b;
         r.divide_by_zero = 1'b0;
      end
      return r;
   endfunction

   function automatic word_type rand_word(int bits);
      word_type w;
      w = {$urandom, $urandom};
      if (bits < udm_pkg::FIELD_WIDTH)
         w &= ~(ONES << bits);
      return w;
   endfunction

   function automatic int pick_gap(bit burst);
      int r;
      if (burst)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      if (mismatch_count < 50)
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic issue(word_type dvd, word_type dvs, logic pinned, divmod_result_type want);
      req_dividend <= dvd;
      req_divisor  <= dvs;
      pin_valid    <= pinned;
      pin_result   <= want;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start        <= 1'b0;
         req_dividend <= rand_word(udm_pkg::FIELD_WIDTH);
         req_divisor  <= rand_word(udm_pkg::FIELD_WIDTH);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic make_operands(output word_type dvd, output word_type dvs);
      int       pick;
      word_type tmp;
      pick = $urandom_range(0, 19);
      dvd  = rand_word(udm_pkg::FIELD_WIDTH);
      dvs  = rand_word(udm_pkg::FIELD_WIDTH);
      case (pick)
         0: dvs = '0;
         1, 2: begin
            dvs |= TOP;
            if ($urandom_range(0, 1))
               dvd |= TOP;
         end
         3, 4, 5: ;
         6, 7, 8, 9: begin
            dvd = rand_word($urandom_range(1, udm_pkg::FIELD_WIDTH));
            dvs = rand_word($urandom_range(1, udm_pkg::FIELD_WIDTH));
         end
         10, 11, 12: dvs = rand_word($urandom_range(1, 16));
         13, 14: begin
            if (dvd > dvs) begin
               tmp = dvd;
               dvd = dvs;
               dvs = tmp;
            end
         end
         15, 16: dvd = dvs + rand_word(8);
         17: dvs = word_type'(1) << $urandom_range(0, udm_pkg::FIELD_WIDTH - 1);
         18: dvd = $urandom_range(0, 1) ? ONES : '0;
         default: dvd = dvs;
      endcase
   endtask

   // response checker and request capture
   always @(posedge clock) begin
      divmod_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request pending, quotient", rsp_quotient, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_quotient !== want.quotient)
                  report_mismatch("quotient", rsp_quotient, want.quotient);
               if (rsp_remainder !== want.remainder)
                  report_mismatch("remainder", rsp_remainder, want.remainder);
               if (rsp_divide_by_zero !== want.divide_by_zero)
                  report_mismatch("divide_by_zero", word_type'(rsp_divide_by_zero),
                                  word_type'(want.divide_by_zero));
            end
         end
         if (start && !busy)
            pending_results.push_back(pin_valid ? pin_result
                                                : divmod_predict(req_dividend, req_divisor));
      end
   end

   initial begin
      word_type dvd;
      word_type dvs;
      bit       burst;
      int       drained;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         issue(DIRECTED[i].dividend, DIRECTED[i].divisor, DIRECTED[i].pinned,
               DIRECTED[i].result);
         pause(pick_gap(1'b0));
      end
      burst = 1'b0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0)
            burst = ($urandom_range(0, 3) == 0);
         make_operands(dvd, dvs);
         issue(dvd, dvs, 1'b0, '0);
         pause(pick_gap(burst));
      end
      start <= 1'b0;
      drained = 0;
      while (pending_results.size() != 0 && drained < DRAIN_LIMIT) begin
         @(posedge clock);
         drained++;
      end
      repeat (udm_pkg::LATENCY + 5) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses missing, count", word_type'(pending_results.size()), '0);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/udm_pkg.sv
hw/rtl/udm_stage.sv
hw/rtl/unsigned_divmod_64.sv
tb/tb_top.sv
